[sv/cartridge_bank_controller_macros.svh]
// assertion helpers for the bank controller modules, included by cbc_bank_regs
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define CBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bank controller check failed");

// consequent must hold in the same cycle as the antecedent
`define CBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bank controller check failed");

`endif

[sv/cbc_pkg.sv]
`default_nettype none

package cbc_pkg;

  // controller kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MBC1 = 2'd1;
  localparam logic [1:0] KIND_MBC3 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_KIND       = 2'd0;
  localparam logic [1:0] REG_RAM_AT_RST = 2'd1;

  // address regions, top two address bits
  localparam logic [1:0] RGN_RAM_EN   = 2'd0;
  localparam logic [1:0] RGN_ROM_LOW  = 2'd1;
  localparam logic [1:0] RGN_UPPER    = 2'd2;
  localparam logic [1:0] RGN_MODE_SEL = 2'd3;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef struct packed {
    logic [14:0] address;
    logic [7:0]  data;
  } cbc_in_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_enabled;
    logic       ram_banking_mode;
  } cbc_out_t;

  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [1:0] data;
  } cbc_cfg_t;

endpackage

`default_nettype wire

[sv/cartridge_bank_controller.sv]
// Cartridge bank controller, MBC1 and MBC3 style.
// Input channel (in_valid, in_stall, in_item): one processor bus write into the
// ROM window, address and data byte. An item is taken at a clock edge with
// in_valid high and in_stall low.
// Output channel (out_valid, out_stall, out_item): after every write, the mapped
// ROM bank, RAM bank, RAM enable flag and banking mode. One result per item.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 selects the controller
// kind, index 1 sets the RAM enable value and loads the live flag. Write only
// while no item is in flight.
// Each item passes the input register, then decode into the bank registers and
// the output register.
// Throughput: one item per cycle while out_stall is low; the bank registers update
// in the same cycle the result is registered, so the next write sees them at once.
// Reset (rst, synchronous): no controller, ROM bank 1, RAM bank 0, RAM
// disabled, ROM banking mode, both stages empty.
// When out_stall holds the result, one more item waits in the input register;
// after that in_stall rises until the output is taken.
`default_nettype none

module cartridge_bank_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cbc_pkg::cbc_in_t  in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cbc_pkg::cbc_out_t      out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [1:0]        cfg_data
);
  import cbc_pkg::*;

  logic     s1_valid;
  cbc_in_t  s1_item;
  logic     out_ready;
  logic     go;
  cbc_out_t result;
  cbc_cfg_t cfg;

  assign cfg      = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign go       = s1_valid && out_ready;
  assign in_stall = s1_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

  // bank registers and write decode
  cbc_bank_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  // result register
  cbc_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (go),
    .result (result),
    .stall  (out_stall),
    .ready  (out_ready),
    .valid  (out_valid),
    .item   (out_item)
  );

endmodule

`default_nettype wire

[sv/cbc_bank_regs.sv]
`default_nettype none

`include "cartridge_bank_controller_macros.svh"

module cbc_bank_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire cbc_pkg::cbc_in_t  item,
  input  wire cbc_pkg::cbc_cfg_t cfg,
  output cbc_pkg::cbc_out_t      result
);
  import cbc_pkg::*;

  logic [1:0] kind;
  logic [4:0] low_bank_bits;
  logic [1:0] high_bank_bits;
  logic [6:0] mapped_rom_bank;
  logic [1:0] mapped_ram_bank;
  logic       ram_enable_flag;
  logic       mode_flag;

  logic [4:0] low_next;
  logic [1:0] high_next;
  logic [6:0] rom_next;
  logic [1:0] ram_next;
  logic       en_next;
  logic       mode_next;

  logic [1:0] region;
  logic [4:0] low_fix;
  logic [6:0] bank7_fix;
  logic       en_key;

  assign region    = item.address[14:13];
  assign low_fix   = (item.data[4:0] == 5'd0) ? 5'd1 : item.data[4:0];
  assign bank7_fix = (item.data[6:0] == 7'd0) ? 7'd1 : item.data[6:0];
  assign en_key    = (item.data[3:0] == RAM_EN_KEY);

  // decode one bus write into register updates
  always_comb begin
    low_next  = low_bank_bits;
    high_next = high_bank_bits;
    rom_next  = mapped_rom_bank;
    ram_next  = mapped_ram_bank;
    en_next   = ram_enable_flag;
    mode_next = mode_flag;
    if (go && kind == KIND_MBC1) begin
      case (region)
        RGN_RAM_EN: begin
          en_next = en_key;
        end
        RGN_ROM_LOW: begin
          low_next = low_fix;
          rom_next = {high_bank_bits, low_fix};
        end
        RGN_UPPER: begin
          high_next = item.data[1:0];
          if (mode_flag) begin
            ram_next = item.data[1:0];
          end else begin
            rom_next = {item.data[1:0], low_bank_bits};
          end
        end
        default: begin
          mode_next = item.data[0];
        end
      endcase
    end else if (go && kind == KIND_MBC3) begin
      case (region)
        RGN_RAM_EN: begin
          en_next = en_key;
        end
        RGN_ROM_LOW: begin
          low_next  = bank7_fix[4:0];
          high_next = bank7_fix[6:5];
          rom_next  = bank7_fix;
        end
        default: begin
        end
      endcase
    end
    // a ram enable register write acts like a cartridge insertion
    if (cfg.we && cfg.index == REG_RAM_AT_RST) begin
      en_next = cfg.data[0];
    end
  end

  // bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind            <= KIND_NONE;
      low_bank_bits   <= 5'd0;
      high_bank_bits  <= 2'd0;
      mapped_rom_bank <= 7'd1;
      mapped_ram_bank <= 2'd0;
      ram_enable_flag <= 1'b0;
      mode_flag       <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == REG_KIND) begin
        kind <= cfg.data;
      end
      low_bank_bits   <= low_next;
      high_bank_bits  <= high_next;
      mapped_rom_bank <= rom_next;
      mapped_ram_bank <= ram_next;
      ram_enable_flag <= en_next;
      mode_flag       <= mode_next;
    end
  end

  assign result = '{rom_bank: rom_next, ram_bank: ram_next,
                    ram_enabled: en_next, ram_banking_mode: mode_next};

  // checks
  `CBC_ASSERT_NEXT(a_mbc3_rom_nonzero, go && kind == KIND_MBC3 && region == RGN_ROM_LOW, mapped_rom_bank != 7'd0)
  `CBC_ASSERT_NEXT(a_idle_kind_holds, go && kind != KIND_MBC1 && kind != KIND_MBC3, $stable(mapped_rom_bank) && $stable(mapped_ram_bank) && $stable(mode_flag))
  `CBC_ASSERT_NEXT(a_mode_sel_keeps_banks, go && kind == KIND_MBC1 && region == RGN_MODE_SEL, $stable(mapped_rom_bank) && $stable(mapped_ram_bank))
  `CBC_ASSERT_NEXT(a_cfg_loads_ram_en, cfg.we && cfg.index == REG_RAM_AT_RST, ram_enable_flag == $past(cfg.data[0]))
  `CBC_ASSERT_NOW(a_mbc3_split, go && kind == KIND_MBC3 && region == RGN_ROM_LOW, rom_next == {high_next, low_next})

endmodule

`default_nettype wire

[sv/cbc_out_reg.sv]
`default_nettype none

module cbc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire cbc_pkg::cbc_out_t result,
  input  wire logic              stall,
  output logic                   ready,
  output logic                   valid,
  output cbc_pkg::cbc_out_t      item
);
  import cbc_pkg::*;

  // register can take a new item when empty or being drained
  assign ready = !valid || !stall;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (ready && load) begin
      item <= result;
    end
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
module tb_top;
  import cbc_pkg::*;

  // codes the package does not name
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned RUN_LIMIT     = 2_000_000;
  localparam int unsigned HOLD_CYCLES   = 40;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  cbc_in_t    in_item;
  logic       out_valid;
  logic       out_stall;
  cbc_out_t   out_item;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [1:0] cfg_data;

  // predicted controller state
  logic [1:0] cur_kind;
  logic       cur_ram_at_rst;
  logic [4:0] bank_low;
  logic [1:0] bank_high;
  logic [6:0] cur_rom_bank;
  logic [1:0] cur_ram_bank;
  logic       cur_ram_en;
  logic       cur_mode;

  cbc_out_t    expected_banks[$];
  int          err_count = 0;
  int          result_count = 0;
  bit          idle_in_on = 1'b1;
  bit          idle_out_on = 1'b1;
  int unsigned hold_request = 0;

  cartridge_bank_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decode one bus write into the predicted bank state
  function automatic cbc_out_t predict_bank_write(cbc_in_t wr);
    cbc_out_t   res;
    logic [6:0] bank;
    if (cur_kind == KIND_MBC1) begin
      case (wr.address[14:13])
        RGN_RAM_EN: cur_ram_en = (wr.data[3:0] == RAM_EN_KEY);
        RGN_ROM_LOW: begin
          bank_low = (wr.data[4:0] == 5'd0) ? 5'd1 : wr.data[4:0];
          cur_rom_bank = {bank_high, bank_low};
        end
        RGN_UPPER: begin
          bank_high = wr.data[1:0];
          if (cur_mode) begin
            cur_ram_bank = bank_high;
          end else begin
            cur_rom_bank = {bank_high, bank_low};
          end
        end
        default: cur_mode = wr.data[0];
      endcase
    end else if (cur_kind == KIND_MBC3) begin
      case (wr.address[14:13])
        RGN_RAM_EN: cur_ram_en = (wr.data[3:0] == RAM_EN_KEY);
        RGN_ROM_LOW: begin
          bank = (wr.data[6:0] == 7'd0) ? 7'd1 : wr.data[6:0];
          bank_low = bank[4:0];
          bank_high = bank[6:5];
          cur_rom_bank = bank;
        end
        default: ;
      endcase
    end
    res.rom_bank = cur_rom_bank;
    res.ram_bank = cur_ram_bank;
    res.ram_enabled = cur_ram_en;
    res.ram_banking_mode = cur_mode;
    return res;
  endfunction

  // random write, often shaped to hit the interesting data values
  function automatic cbc_in_t random_bank_write();
    cbc_in_t wr;
    wr.address = 15'($urandom);
    wr.data = 8'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      case (wr.address[14:13])
        RGN_RAM_EN:  wr.data[3:0] = RAM_EN_KEY;
        RGN_ROM_LOW: wr.data[4:0] = 5'd0;
        RGN_UPPER:   wr.data[7:2] = 6'd0;
        default:     wr.data[0] = ~wr.data[0];
      endcase
    end
    return wr;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch on result %0d, %s: got %0d, expected %0d",
             result_count, what, got, exp_val);
    err_count++;
  endtask

  // register write, only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KIND: cur_kind = val;
      REG_RAM_AT_RST: begin
        cur_ram_at_rst = val[0];
        cur_ram_en = val[0];
      end
      default: ;
    endcase
  endtask

  // offer one item, hold it until taken, then record its expected result
  task automatic send_write(input logic [14:0] addr, input logic [7:0] data);
    cbc_in_t     wr;
    int unsigned gap;
    wr.address = addr;
    wr.data = data;
    gap = idle_in_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= wr;
    do @(posedge clk); while (in_stall);
    expected_banks.push_back(predict_bank_write(wr));
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_banks_settled();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_banks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // no controller after reset, every write ignored
  task automatic test_ignored_writes();
    send_write({RGN_RAM_EN, 13'h0000}, 8'h0A);
    send_write({RGN_ROM_LOW, 13'h1FFF}, 8'h05);
    send_write({RGN_UPPER, 13'h0A55}, 8'h03);
    send_write({RGN_MODE_SEL, 13'h1FFF}, 8'hFF);
    wait_banks_settled();
  endtask

  // all four regions in mbc1 style
  task automatic test_mbc1_regions();
    write_reg(REG_KIND, KIND_MBC1);
    // upper bits with low bits still zero
    send_write({RGN_UPPER, 13'h0000}, 8'h02);
    send_write({RGN_RAM_EN, 13'h0000}, 8'h0A);
    send_write({RGN_RAM_EN, 13'h1FFF}, 8'hFF);
    send_write({RGN_RAM_EN, 13'h0800}, 8'hFA);
    send_write({RGN_ROM_LOW, 13'h0000}, 8'h00);
    send_write({RGN_ROM_LOW, 13'h1FFF}, 8'hFF);
    // zero in the low five bits only
    send_write({RGN_ROM_LOW, 13'h0000}, 8'hE0);
    send_write({RGN_UPPER, 13'h1FFF}, 8'hFF);
    send_write({RGN_MODE_SEL, 13'h0000}, 8'h01);
    send_write({RGN_UPPER, 13'h0000}, 8'hFE);
    // mode select looks at bit 0 only
    send_write({RGN_MODE_SEL, 13'h1FFF}, 8'hFE);
    send_write({RGN_MODE_SEL, 13'h1000}, 8'hFF);
    wait_banks_settled();
  endtask

  // mbc3 style, kind change keeps the bank state
  task automatic test_mbc3_regions();
    write_reg(REG_KIND, KIND_MBC3);
    send_write({RGN_ROM_LOW, 13'h0000}, 8'h00);
    send_write({RGN_ROM_LOW, 13'h1FFF}, 8'h7F);
    send_write({RGN_ROM_LOW, 13'h0000}, 8'h80);
    send_write({RGN_UPPER, 13'h0000}, 8'h03);
    send_write({RGN_MODE_SEL, 13'h1FFF}, 8'h00);
    send_write({RGN_RAM_EN, 13'h1FFF}, 8'h0A);
    wait_banks_settled();
  endtask

  // unused kind, ram enable load, registers past the list
  task automatic test_register_specials();
    write_reg(REG_KIND, KIND_UNUSED);
    send_write({RGN_ROM_LOW, 13'h0000}, 8'h10);
    send_write({RGN_RAM_EN, 13'h0000}, 8'h00);
    wait_banks_settled();
    write_reg(REG_RAM_AT_RST, 2'd1);
    write_reg(REG_RAM_AT_RST, 2'd2);
    write_reg(REG_SPARE_A, 2'd3);
    write_reg(REG_SPARE_B, 2'd1);
    send_write({RGN_UPPER, 13'h1FFF}, 8'hFF);
    wait_banks_settled();
    write_reg(REG_KIND, KIND_NONE);
    wait_banks_settled();
    write_reg(REG_RAM_AT_RST, 2'd3);
    send_write({RGN_RAM_EN, 13'h0000}, 8'h00);
    wait_banks_settled();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    cbc_in_t wr;
    write_reg(REG_KIND, KIND_MBC1);
    idle_in_on = 1'b0;
    idle_out_on = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (24) begin
      wr = random_bank_write();
      send_write(wr.address, wr.data);
    end
    wait_banks_settled();
  endtask

  // random phases over several register settings
  task automatic test_random_phases();
    cbc_in_t     wr;
    logic [1:0]  kind;
    int unsigned num_items;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: kind = KIND_MBC1;
        1: kind = KIND_MBC3;
        2: kind = KIND_NONE;
        3: kind = KIND_UNUSED;
        default: kind = ($urandom_range(0, 1) != 0) ? KIND_MBC1 : KIND_MBC3;
      endcase
      write_reg(REG_KIND, kind);
      write_reg(REG_RAM_AT_RST, 2'($urandom_range(0, 3)));
      if (p == 4) begin
        idle_in_on = 1'b0;
        idle_out_on = 1'b0;
      end else if (p == 5) begin
        idle_in_on = 1'b1;
        idle_out_on = 1'b1;
      end else begin
        idle_in_on = ($urandom_range(0, 2) != 0);
        idle_out_on = ($urandom_range(0, 2) != 0);
      end
      num_items = (kind == KIND_MBC1 || kind == KIND_MBC3) ? 48 : 12;
      repeat (num_items) begin
        wr = random_bank_write();
        send_write(wr.address, wr.data);
      end
      wait_banks_settled();
    end
  endtask

  // receiver: per item stall draw, or a long hold when asked
  initial begin : receiver
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = idle_out_on ? $urandom_range(0, 4) : 0;
      end
      if (n != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare each taken item with the oldest expectation
  always @(posedge clk) begin : result_check
    cbc_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_banks.size() == 0) begin
        report_mismatch("item with no expectation", 0, 0);
      end else begin
        want = expected_banks.pop_front();
        if (out_item.rom_bank !== want.rom_bank)
          report_mismatch("rom_bank", out_item.rom_bank, want.rom_bank);
        if (out_item.ram_bank !== want.ram_bank)
          report_mismatch("ram_bank", out_item.ram_bank, want.ram_bank);
        if (out_item.ram_enabled !== want.ram_enabled)
          report_mismatch("ram_enabled", out_item.ram_enabled, want.ram_enabled);
        if (out_item.ram_banking_mode !== want.ram_banking_mode)
          report_mismatch("ram_banking_mode", out_item.ram_banking_mode,
                          want.ram_banking_mode);
      end
      result_count++;
    end
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // test sequence
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_KIND;
    cfg_data = 2'd0;
    cur_kind = KIND_NONE;
    cur_ram_at_rst = 1'b0;
    bank_low = 5'd0;
    bank_high = 2'd0;
    cur_rom_bank = 7'd1;
    cur_ram_bank = 2'd0;
    cur_ram_en = 1'b0;
    cur_mode = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_ignored_writes();
    test_mbc1_regions();
    test_mbc3_regions();
    test_register_specials();
    test_backpressure();
    test_random_phases();
    wait_banks_settled();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/cbc_pkg.sv
sv/cbc_bank_regs.sv
sv/cbc_out_reg.sv
sv/cartridge_bank_controller.sv
sim/tb_top.sv
